// ----- hdl/cpd_pkg.sv -----
`timescale 1ns / 1ps

package cpd_pkg;

  localparam int unsigned BufDepth   = 4096;
  localparam int unsigned WindowLen  = 96;
  localparam int unsigned TermMax    = 8;
  localparam int unsigned RawDepth   = 12;
  localparam int unsigned LowDepth   = 13;
  localparam int unsigned KeyCount   = 5;
  localparam int unsigned TextW      = LowDepth * 8;

  localparam logic [6:0] AgeMax = 7'd127;

  typedef enum logic [1:0] {
    OpStart = 2'd0,
    OpByte  = 2'd1,
    OpTick  = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    StReceiving = 2'd0,
    StFound     = 2'd1,
    StFull      = 2'd2,
    StTimeout   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RegTermBytes = 2'd0,
    RegTermLen   = 2'd1,
    RegBufLimit  = 2'd2,
    RegTimeout   = 2'd3
  } cfg_reg_e;

  // keyword order: press, [enter], " enter", continue, press any key
  localparam int unsigned KeyPress    = 0;
  localparam int unsigned KeyBrEnter  = 1;
  localparam int unsigned KeySpEnter  = 2;
  localparam int unsigned KeyContinue = 3;
  localparam int unsigned KeyAnyKey   = 4;

  localparam logic [KeyCount-1:0][3:0] KeyLen = {4'd13, 4'd8, 4'd6, 4'd7, 4'd5};

  localparam logic [KeyCount-1:0][TextW-1:0] KeyText = {
    TextW'("press any key"),
    TextW'("continue"),
    TextW'(" enter"),
    TextW'("[enter]"),
    TextW'("press")
  };

  localparam logic [TextW-1:0] PromptShort = TextW'("pylon>");
  localparam logic [TextW-1:0] PromptDebug = TextW'({"pylon_", "debug>"});
  localparam logic [3:0]       PromptShortLen = 4'd6;
  localparam logic [3:0]       PromptDebugLen = 4'd12;

  typedef struct packed {
    logic                found;
    logic [KeyCount-1:0] key_hit;
  } cpd_scan_t;

  // newest byte at index 0, last text character in the low byte
  function automatic logic suffix_hit(input logic [LowDepth-1:0][7:0] win,
                                      input logic [TextW-1:0] text,
                                      input logic [3:0] len);
    logic hit;
    hit = 1'b1;
    for (int i = 0; i < LowDepth; i++) begin
      if ((4'(i) < len) && (win[i] != text[8*i +: 8])) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

endpackage

// ----- hdl/console_prompt_detector_core.sv -----
`timescale 1ns / 1ps

// channel  | handshake            | payload
// ---------+----------------------+-----------------------------------------------
// in       | in_valid_i/in_ready_o | opcode_i, data_byte_i
// out      | out_valid_o/out_ready_i | status_o, store_byte_o, write_index_o,
//          |                      | byte_count_o, send_return_o
// cfg      | cfg_we_i (no wait)   | cfg_index_i, cfg_data_i
//
// one item per cycle sustained while the output is not stalled; an item reaches the output through
// the input register, then the result register, with the match logic and state update between
// reset clears the configuration to its defaults and starts a reception
// a stalled output holds the result; the input register still fills behind it,
// so in_ready_o drops only when both stages hold an item

module console_prompt_detector_core
  import cpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic        store_byte_o,
  output logic [11:0] write_index_o,
  output logic [11:0] byte_count_o,
  output logic        send_return_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  // configuration
  logic [TermMax*8-1:0] term_bytes_q;
  logic [3:0]           term_len_q;
  logic [12:0]          buf_limit_q;
  logic [31:0]          timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_bytes_q <= (TermMax*8)'(62);
      term_len_q   <= 4'd1;
      buf_limit_q  <= 13'(BufDepth);
      timeout_q    <= 32'd1000;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegTermBytes: term_bytes_q <= cfg_data_i[TermMax*8-1:0];
        RegTermLen:   term_len_q   <= cfg_data_i[3:0];
        RegBufLimit:  buf_limit_q  <= cfg_data_i[12:0];
        RegTimeout:   timeout_q    <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic       s1_valid_q;
  logic [1:0] s1_op_q;
  logic [7:0] s1_byte_q;
  logic       out_free;
  logic       s1_adv;

  assign out_free   = !out_valid_o || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_op_q   <= opcode_i;
      s1_byte_q <= data_byte_i;
    end
  end

  // reception state
  logic [RawDepth-2:0][7:0] raw_q, raw_d;
  logic [LowDepth-2:0][7:0] low_q, low_d;
  logic [KeyCount-1:0][6:0] age_q, age_d;
  logic [11:0]              count_q, count_d;
  logic [31:0]              ticks_q, ticks_d;
  status_e                  outcome_q, outcome_d;

  logic [RawDepth-1:0][7:0] raw_win;
  logic [LowDepth-1:0][7:0] low_win;
  logic [7:0]               lc;
  logic [12:0]              lim;
  logic [12:0]              lim_m1;
  logic [3:0]               tlen;
  logic [11:0]              count_inc;
  logic [31:0]              ticks_inc;
  logic [KeyCount-1:0]      present;
  logic                     need_ret;
  cpd_scan_t                scan;

  logic store_d, ret_d;
  logic [11:0] widx_d;

  assign lc      = ((s1_byte_q >= 8'h41) && (s1_byte_q <= 8'h5a)) ? (s1_byte_q + 8'd32)
                                                                  : s1_byte_q;
  assign raw_win = {raw_q, s1_byte_q};
  assign low_win = {low_q, lc};

  assign lim = (buf_limit_q < 13'd2) ? 13'd2
             : (buf_limit_q > 13'(BufDepth)) ? 13'(BufDepth) : buf_limit_q;
  assign lim_m1    = lim - 13'd1;
  assign tlen      = (term_len_q > 4'(TermMax)) ? 4'(TermMax) : term_len_q;
  assign count_inc = count_q + 12'd1;
  assign ticks_inc = (ticks_q != 32'hffff_ffff) ? (ticks_q + 32'd1) : ticks_q;

  cpd_scan u_scan (
    .raw_win_i    (raw_win),
    .low_win_i    (low_win),
    .term_bytes_i (term_bytes_q),
    .term_len_i   (tlen),
    .count_i      (count_inc),
    .scan_o       (scan)
  );

  always_comb begin
    for (int k = 0; k < KeyCount; k++) begin
      if (scan.key_hit[k]) begin
        age_d[k] = 7'd0;
      end else if (age_q[k] != AgeMax) begin
        age_d[k] = age_q[k] + 7'd1;
      end else begin
        age_d[k] = age_q[k];
      end
      present[k] = ({1'b0, age_d[k]} + 8'(KeyLen[k])) <= 8'(WindowLen);
    end
  end

  assign need_ret = present[KeyContinue]
                    && ((present[KeyPress] && (present[KeyBrEnter] || present[KeySpEnter]))
                        || present[KeyAnyKey]);

  always_comb begin
    raw_d     = raw_q;
    low_d     = low_q;
    count_d   = count_q;
    ticks_d   = ticks_q;
    outcome_d = outcome_q;
    store_d   = 1'b0;
    ret_d     = 1'b0;
    widx_d    = 12'd0;
    unique case (s1_op_q)
      OpStart: begin
        raw_d     = '0;
        low_d     = '0;
        count_d   = 12'd0;
        ticks_d   = 32'd0;
        outcome_d = (timeout_q == 32'd0) ? StTimeout : StReceiving;
      end
      OpTick: begin
        if (outcome_q == StReceiving) begin
          ticks_d = ticks_inc;
          if (ticks_inc >= timeout_q) begin
            outcome_d = StTimeout;
          end
        end
      end
      OpByte: begin
        if (outcome_q == StReceiving) begin
          if ({1'b0, count_q} >= lim_m1) begin
            outcome_d = StFull;
          end else begin
            store_d = 1'b1;
            widx_d  = count_q;
            count_d = count_inc;
            raw_d   = raw_win[RawDepth-2:0];
            low_d   = low_win[LowDepth-2:0];
            if (scan.found) begin
              outcome_d = StFound;
            end else begin
              ret_d = need_ret;
              if ({1'b0, count_inc} >= lim_m1) begin
                outcome_d = StFull;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  logic age_upd, age_clr;
  assign age_upd = s1_adv && (s1_op_q == OpByte) && store_d;
  assign age_clr = s1_adv && (s1_op_q == OpStart);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q     <= '0;
      low_q     <= '0;
      age_q     <= {KeyCount{AgeMax}};
      count_q   <= 12'd0;
      ticks_q   <= 32'd0;
      outcome_q <= StReceiving;
    end else begin
      if (s1_adv) begin
        raw_q     <= raw_d;
        low_q     <= low_d;
        count_q   <= count_d;
        ticks_q   <= ticks_d;
        outcome_q <= outcome_d;
      end
      if (age_clr) begin
        age_q <= {KeyCount{AgeMax}};
      end else if (age_upd) begin
        age_q <= age_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_free) begin
      out_valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      status_o      <= outcome_d;
      store_byte_o  <= store_d;
      write_index_o <= widx_d;
      byte_count_o  <= count_d;
      send_return_o <= ret_d;
    end
  end

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && send_return_o |-> store_byte_o && (status_o != StFound))
    else $error("send_return without an accepted byte or on a found byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && store_byte_o |-> byte_count_o == (write_index_o + 12'd1))
    else $error("byte count does not follow write index");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_free |=> s1_valid_q && $stable(s1_op_q) && $stable(s1_byte_q))
    else $error("input register lost an item while the output stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> $stable(count_q) && $stable(outcome_q))
    else $error("reception state changed without an item");

endmodule

// ----- hdl/cpd_scan.sv -----
`timescale 1ns / 1ps

module cpd_scan
  import cpd_pkg::*;
(
  input  logic [RawDepth-1:0][7:0] raw_win_i,
  input  logic [LowDepth-1:0][7:0] low_win_i,
  input  logic [TermMax*8-1:0]     term_bytes_i,
  input  logic [3:0]               term_len_i,
  input  logic [11:0]              count_i,
  output cpd_scan_t                scan_o
);

  logic [LowDepth-1:0][7:0] raw_pad;
  logic [TermMax-1:0]       term_ok;
  logic                     term_hit;
  logic                     short_hit;
  logic                     debug_hit;

  assign raw_pad = {{(LowDepth - RawDepth){8'h00}}, raw_win_i};

  always_comb begin
    for (int i = 0; i < TermMax; i++) begin
      term_ok[i] = (4'(i) >= term_len_i) || (raw_win_i[i] == term_bytes_i[8*i +: 8]);
    end
  end

  assign term_hit  = (term_len_i != 4'd0) && (count_i >= {8'd0, term_len_i}) && (&term_ok);
  assign short_hit = (count_i >= 12'(PromptShortLen))
                     && suffix_hit(raw_pad, PromptShort, PromptShortLen);
  assign debug_hit = (count_i >= 12'(PromptDebugLen))
                     && suffix_hit(raw_pad, PromptDebug, PromptDebugLen);

  always_comb begin
    scan_o.found = term_hit || short_hit || debug_hit;
    for (int k = 0; k < KeyCount; k++) begin
      scan_o.key_hit[k] = suffix_hit(low_win_i, KeyText[k], KeyLen[k]);
    end
  end

endmodule
